[rtl/core/ploq_pkg.sv]
package ploq_pkg;

   // Field widths of the request and response words.
   localparam int HANDLE_W = 8;
   localparam int PRICE_W  = 24;
   localparam int SHARES_W = 32;
   localparam int COUNT_W  = 9;
   localparam int SIZE_W   = 40;
   localparam int VOLUME_W = 64;
   localparam int STATUS_W = 3;

   // Operation codes carried by the request word.
   typedef enum logic [1:0] {
      FN_PUSH   = 2'd0,
      FN_POP    = 2'd1,
      FN_REMOVE = 2'd2,
      FN_NONE   = 2'd3
   } func_type;

   // Completion codes carried by the response word.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 3'd0,
      STAT_PRICE = 3'd1,
      STAT_EMPTY = 3'd2,
      STAT_NOTQ  = 3'd3,
      STAT_DUP   = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_CHECK,
      SEQ_READ,
      SEQ_APPLY
   } seq_state_type;

   // Strobes from the sequencer to the datapath.
   typedef struct packed {
      logic idle;
      logic take;
      logic check;
      logic finish;
      logic read;
      logic apply;
   } seq_ctrl_type;

   // Strobes to the totals unit.
   typedef struct packed {
      logic capture;
      logic apply;
      logic add;
   } tot_ctrl_type;

endpackage

[rtl/core/price_level_order_queue_core.sv]
// One price level of an order book: a doubly linked queue of order slots
// with push at the head, pop of the oldest order and removal by handle.
// A request word is taken when the block is idle. A rejected push, remove
// or pop, or an unknown function, registers its response at the end of the
// check step; a successful operation registers it at the end of the update
// step, after a check step, a slot memory read step (registered read
// ports) that also forms shares times price in the one multiplier, and the
// update step itself. The next word is taken once the block is back in
// idle, after the response is registered. While an earlier response is
// still stalled, the block waits in the check step with a rejected word or
// in the read step with a successful one. The valid map is in flip-flops
// cleared by reset, so no clearing pass is needed.
// Only handles below both SLOTS and 256 can ever be queued.
module price_level_order_queue_core #(
   parameter int SLOTS = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ploq_pkg::PRICE_W-1:0]  csr_level_price,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_func,
   input  logic [ploq_pkg::HANDLE_W-1:0] req_order_handle,
   input  logic [ploq_pkg::PRICE_W-1:0]  req_order_price,
   input  logic [ploq_pkg::SHARES_W-1:0] req_order_shares,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ploq_pkg::STATUS_W-1:0] rsp_status,
   output logic [ploq_pkg::HANDLE_W-1:0] rsp_out_handle,
   output logic [ploq_pkg::SHARES_W-1:0] rsp_out_shares,
   output logic [ploq_pkg::COUNT_W-1:0]  rsp_order_count,
   output logic [ploq_pkg::SIZE_W-1:0]   rsp_total_size,
   output logic [ploq_pkg::VOLUME_W-1:0] rsp_total_volume
);

   localparam int HW       = ploq_pkg::HANDLE_W;
   localparam int HANDLES  = 1 << HW;
   localparam int USED     = (SLOTS < HANDLES) ? SLOTS : HANDLES;
   localparam int IW       = $clog2(USED);
   localparam int CW       = ploq_pkg::COUNT_W;

   ploq_pkg::seq_ctrl_type ctrl;
   ploq_pkg::tot_ctrl_type tot_ctrl;

   logic [ploq_pkg::PRICE_W-1:0]  level_price_ff;

   // Latched request word.
   ploq_pkg::func_type            func_ff;
   logic [HW-1:0]                 handle_ff;
   logic [ploq_pkg::PRICE_W-1:0]  price_ff;
   logic [ploq_pkg::SHARES_W-1:0] shares_ff;

   // Queue state.
   logic [IW-1:0]                 slot_ff;
   logic [IW-1:0]                 head_ff;
   logic [IW-1:0]                 head_in;
   logic [IW-1:0]                 tail_ff;
   logic [IW-1:0]                 tail_in;
   logic [USED-1:0]               valid_ff;
   logic [USED-1:0]               valid_in;

   // Response register.
   logic                          rsp_valid_ff;
   ploq_pkg::status_type          status_ff;
   logic [HW-1:0]                 out_handle_ff;
   logic [ploq_pkg::SHARES_W-1:0] out_shares_ff;
   logic [CW-1:0]                 count_out_ff;
   logic [ploq_pkg::SIZE_W-1:0]   size_out_ff;
   logic [ploq_pkg::VOLUME_W-1:0] volume_out_ff;

   // Check results.
   logic                          in_range;
   logic [IW-1:0]                 h_idx;
   logic                          is_push;
   logic                          finish_now;
   logic                          push_go;
   logic                          out_free;
   ploq_pkg::status_type          chk_status;
   logic [IW-1:0]                 target_idx;

   // Slot memory ports.
   logic                          next_we;
   logic [IW-1:0]                 next_waddr;
   logic [IW-1:0]                 next_wdata;
   logic                          prev_we;
   logic [IW-1:0]                 prev_waddr;
   logic [IW-1:0]                 prev_wdata;
   logic                          shares_we;
   logic [IW-1:0]                 rd_next;
   logic [IW-1:0]                 rd_prev;
   logic [ploq_pkg::SHARES_W-1:0] rd_shares;
   logic [ploq_pkg::SHARES_W-1:0] op_shares;

   // Totals.
   logic [CW-1:0]                 count;
   logic [ploq_pkg::SIZE_W-1:0]   size;
   logic [ploq_pkg::VOLUME_W-1:0] volume;
   logic [CW-1:0]                 count_next;
   logic [ploq_pkg::SIZE_W-1:0]   size_next;
   logic [ploq_pkg::VOLUME_W-1:0] volume_next;

   ploq_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .finish_now (finish_now),
      .out_free   (out_free),
      .ctrl       (ctrl)
   );

   assign req_stall = !ctrl.idle;
   assign csr_ready = ctrl.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Level price register.
   always_ff @(posedge clock) begin
      if (reset) begin
         level_price_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         level_price_ff <= csr_level_price;
      end
   end

   // Request word latch.
   always_ff @(posedge clock) begin
      if (ctrl.take) begin
         func_ff   <= ploq_pkg::func_type'(req_func);
         handle_ff <= req_order_handle;
         price_ff  <= req_order_price;
         shares_ff <= req_order_shares;
      end
   end

   // Check the request against the queue and pick the slot to work on.
   always_comb begin
      in_range   = (int'(handle_ff) < USED);
      h_idx      = IW'(handle_ff);
      is_push    = (func_ff == ploq_pkg::FN_PUSH);
      finish_now = 1'b0;
      push_go    = 1'b0;
      chk_status = ploq_pkg::STAT_OK;
      target_idx = h_idx;
      case (func_ff)
         ploq_pkg::FN_PUSH: begin
            if (price_ff != level_price_ff) begin
               finish_now = 1'b1;
               chk_status = ploq_pkg::STAT_PRICE;
            end else if (!in_range) begin
               finish_now = 1'b1;
               chk_status = ploq_pkg::STAT_NOTQ;
            end else if (valid_ff[h_idx]) begin
               finish_now = 1'b1;
               chk_status = ploq_pkg::STAT_DUP;
            end else begin
               push_go = 1'b1;
            end
         end
         ploq_pkg::FN_POP: begin
            target_idx = tail_ff;
            if ((count == '0) || !valid_ff[tail_ff]) begin
               finish_now = 1'b1;
               chk_status = ploq_pkg::STAT_EMPTY;
            end
         end
         ploq_pkg::FN_REMOVE: begin
            if (!in_range || !valid_ff[h_idx]) begin
               finish_now = 1'b1;
               chk_status = ploq_pkg::STAT_NOTQ;
            end
         end
         default: begin
            finish_now = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.check) begin
         slot_ff <= target_idx;
      end
   end

   // Slot memory writes: a push fills its slot during the check, and the
   // neighbor links are patched in the update cycle.
   always_comb begin
      next_we    = (ctrl.check && push_go) ||
                   (ctrl.apply && !is_push && (slot_ff != head_ff));
      next_waddr = ctrl.check ? h_idx : rd_prev;
      next_wdata = ctrl.check ? head_ff : rd_next;
      prev_we    = (ctrl.check && push_go) ||
                   (ctrl.apply && is_push && (count != '0)) ||
                   (ctrl.apply && !is_push && (slot_ff != tail_ff));
      if (ctrl.check) begin
         prev_waddr = h_idx;
         prev_wdata = '0;
      end else if (is_push) begin
         prev_waddr = head_ff;
         prev_wdata = slot_ff;
      end else begin
         prev_waddr = rd_next;
         prev_wdata = rd_prev;
      end
      shares_we  = ctrl.check && push_go;
   end

   ploq_slot_mem #(
      .DEPTH (USED),
      .IW    (IW)
   ) u_slot_mem (
      .clock        (clock),
      .rd_en        (ctrl.check),
      .rd_addr      (target_idx),
      .next_we      (next_we),
      .next_waddr   (next_waddr),
      .next_wdata   (next_wdata),
      .prev_we      (prev_we),
      .prev_waddr   (prev_waddr),
      .prev_wdata   (prev_wdata),
      .shares_we    (shares_we),
      .shares_waddr (h_idx),
      .shares_wdata (shares_ff),
      .rd_next      (rd_next),
      .rd_prev      (rd_prev),
      .rd_shares    (rd_shares)
   );

   // Shares moved by this operation feed the totals unit.
   always_comb begin
      op_shares        = is_push ? shares_ff : rd_shares;
      tot_ctrl.capture = ctrl.read;
      tot_ctrl.apply   = ctrl.apply;
      tot_ctrl.add     = is_push;
   end

   ploq_totals u_totals (
      .clock       (clock),
      .reset       (reset),
      .level_price (level_price_ff),
      .shares      (op_shares),
      .ctrl        (tot_ctrl),
      .count       (count),
      .size        (size),
      .volume      (volume),
      .count_next  (count_next),
      .size_next   (size_next),
      .volume_next (volume_next)
   );

   // Head, tail and valid map after a push or an unlink.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      valid_in = valid_ff;
      if (ctrl.apply) begin
         if (is_push) begin
            valid_in[slot_ff] = 1'b1;
            if (count == '0) begin
               tail_in = slot_ff;
            end
            head_in = slot_ff;
         end else begin
            valid_in[slot_ff] = 1'b0;
            if (slot_ff == tail_ff) begin
               tail_in = rd_prev;
            end
            if (slot_ff == head_ff) begin
               head_in = rd_next;
            end
            if (count == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         valid_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         valid_ff <= valid_in;
      end
   end

   // Response register: loaded by a finished check or by the update cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.finish || ctrl.apply) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         status_ff     <= chk_status;
         out_handle_ff <= handle_ff;
         out_shares_ff <= '0;
         count_out_ff  <= count;
         size_out_ff   <= size;
         volume_out_ff <= volume;
      end else if (ctrl.apply) begin
         status_ff     <= ploq_pkg::STAT_OK;
         out_handle_ff <= (func_ff == ploq_pkg::FN_POP) ? HW'(slot_ff) : handle_ff;
         out_shares_ff <= is_push ? '0 : rd_shares;
         count_out_ff  <= count_next;
         size_out_ff   <= size_next;
         volume_out_ff <= volume_next;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_handle   = out_handle_ff;
   assign rsp_out_shares   = out_shares_ff;
   assign rsp_order_count  = count_out_ff;
   assign rsp_total_size   = size_out_ff;
   assign rsp_total_volume = volume_out_ff;

endmodule

[rtl/core/ploq_slot_mem.sv]
module ploq_slot_mem #(
   parameter int DEPTH = 256,
   parameter int IW    = 8
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [IW-1:0]                 rd_addr,
   input  logic                          next_we,
   input  logic [IW-1:0]                 next_waddr,
   input  logic [IW-1:0]                 next_wdata,
   input  logic                          prev_we,
   input  logic [IW-1:0]                 prev_waddr,
   input  logic [IW-1:0]                 prev_wdata,
   input  logic                          shares_we,
   input  logic [IW-1:0]                 shares_waddr,
   input  logic [ploq_pkg::SHARES_W-1:0] shares_wdata,
   output logic [IW-1:0]                 rd_next,
   output logic [IW-1:0]                 rd_prev,
   output logic [ploq_pkg::SHARES_W-1:0] rd_shares
);

   logic [IW-1:0]                 next_mem [DEPTH];
   logic [IW-1:0]                 prev_mem [DEPTH];
   logic [ploq_pkg::SHARES_W-1:0] shares_mem [DEPTH];

   logic [IW-1:0]                 rd_next_ff;
   logic [IW-1:0]                 rd_prev_ff;
   logic [ploq_pkg::SHARES_W-1:0] rd_shares_ff;

   // Link toward the tail: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (rd_en) begin
         rd_next_ff <= next_mem[rd_addr];
      end
   end

   // Link toward the head.
   always_ff @(posedge clock) begin
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (rd_en) begin
         rd_prev_ff <= prev_mem[rd_addr];
      end
   end

   // Share quantity of each slot.
   always_ff @(posedge clock) begin
      if (shares_we) begin
         shares_mem[shares_waddr] <= shares_wdata;
      end
      if (rd_en) begin
         rd_shares_ff <= shares_mem[rd_addr];
      end
   end

   assign rd_next   = rd_next_ff;
   assign rd_prev   = rd_prev_ff;
   assign rd_shares = rd_shares_ff;

endmodule

[rtl/core/ploq_totals.sv]
module ploq_totals (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ploq_pkg::PRICE_W-1:0]  level_price,
   input  logic [ploq_pkg::SHARES_W-1:0] shares,
   input  ploq_pkg::tot_ctrl_type        ctrl,
   output logic [ploq_pkg::COUNT_W-1:0]  count,
   output logic [ploq_pkg::SIZE_W-1:0]   size,
   output logic [ploq_pkg::VOLUME_W-1:0] volume,
   output logic [ploq_pkg::COUNT_W-1:0]  count_next,
   output logic [ploq_pkg::SIZE_W-1:0]   size_next,
   output logic [ploq_pkg::VOLUME_W-1:0] volume_next
);

   localparam int PW = ploq_pkg::PRICE_W + ploq_pkg::SHARES_W;
   localparam int CW = ploq_pkg::COUNT_W;
   localparam int SW = ploq_pkg::SIZE_W;
   localparam int VW = ploq_pkg::VOLUME_W;

   logic [PW-1:0] price_x;
   logic [PW-1:0] shares_x;
   logic [PW-1:0] product_in;
   logic [PW-1:0] product_ff;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [SW-1:0] size_ff;
   logic [SW-1:0] size_in;
   logic [VW-1:0] volume_ff;
   logic [VW-1:0] volume_in;

   // Volume of one order: shares times the level price, registered.
   always_comb begin
      price_x    = PW'(level_price);
      shares_x   = PW'(shares);
      product_in = price_x * shares_x;
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         product_ff <= product_in;
      end
   end

   // Add or take off one order; the last order leaving clears the sums.
   always_comb begin
      count_in  = count_ff;
      size_in   = size_ff;
      volume_in = volume_ff;
      if (ctrl.apply) begin
         if (ctrl.add) begin
            count_in  = count_ff + CW'(1);
            size_in   = size_ff + SW'(shares);
            volume_in = volume_ff + VW'(product_ff);
         end else if (count_ff == CW'(1)) begin
            count_in  = '0;
            size_in   = '0;
            volume_in = '0;
         end else begin
            count_in  = count_ff - CW'(1);
            size_in   = size_ff - SW'(shares);
            volume_in = volume_ff - VW'(product_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         size_ff   <= '0;
         volume_ff <= '0;
      end else begin
         count_ff  <= count_in;
         size_ff   <= size_in;
         volume_ff <= volume_in;
      end
   end

   assign count       = count_ff;
   assign size        = size_ff;
   assign volume      = volume_ff;
   assign count_next  = count_in;
   assign size_next   = size_in;
   assign volume_next = volume_in;

endmodule

[rtl/core/ploq_seq.sv]
module ploq_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   finish_now,
   input  logic                   out_free,
   output ploq_pkg::seq_ctrl_type ctrl
);

   ploq_pkg::seq_state_type state_ff;
   ploq_pkg::seq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ploq_pkg::SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: rejected operations and unknown functions finish from the check once the output is free.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ploq_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               state_in = ploq_pkg::SEQ_CHECK;
            end
         end
         ploq_pkg::SEQ_CHECK: begin
            if (!finish_now) begin
               state_in = ploq_pkg::SEQ_READ;
            end else if (out_free) begin
               state_in = ploq_pkg::SEQ_IDLE;
            end
         end
         ploq_pkg::SEQ_READ: begin
            if (out_free) begin
               state_in = ploq_pkg::SEQ_APPLY;
            end
         end
         ploq_pkg::SEQ_APPLY: begin
            state_in = ploq_pkg::SEQ_IDLE;
         end
         default: begin
            state_in = ploq_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Strobes for the datapath.
   always_comb begin
      ctrl.idle   = (state_ff == ploq_pkg::SEQ_IDLE);
      ctrl.take   = (state_ff == ploq_pkg::SEQ_IDLE) && req_valid;
      ctrl.check  = (state_ff == ploq_pkg::SEQ_CHECK);
      ctrl.finish = (state_ff == ploq_pkg::SEQ_CHECK) && finish_now && out_free;
      ctrl.read   = (state_ff == ploq_pkg::SEQ_READ);
      ctrl.apply  = (state_ff == ploq_pkg::SEQ_APPLY);
   end

endmodule

[rtl/core/ploq_checker.sv]
module ploq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [ploq_pkg::STATUS_W-1:0] rsp_status,
   input logic [ploq_pkg::HANDLE_W-1:0] rsp_out_handle,
   input logic [ploq_pkg::SHARES_W-1:0] rsp_out_shares,
   input logic [ploq_pkg::COUNT_W-1:0]  rsp_order_count,
   input logic [ploq_pkg::SIZE_W-1:0]   rsp_total_size,
   input logic [ploq_pkg::VOLUME_W-1:0] rsp_total_volume
);

   // A stalled response holds its status, handle, shares and volume.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_out_handle) && $stable(rsp_out_shares) &&
         $stable(rsp_total_volume))
      else $error("response word changed while stalled");

   // The block works on one word at a time.
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while a word is in progress");

   // A new response only follows a word in progress.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a word in progress");

   // An empty level carries no shares and no volume.
   a_empty_totals: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_order_count == '0) |->
         (rsp_total_size == '0) && (rsp_total_volume == '0))
      else $error("empty level reports nonzero totals");

   // A failed operation moves no shares.
   a_fail_shares: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ploq_pkg::STAT_OK) |-> (rsp_out_shares == '0))
      else $error("failed operation reports shares");

endmodule

bind price_level_order_queue_core ploq_checker u_ploq_checker (.*);
